/* hdl/psu_pkg.sv */
// Types, constants and codes shared by the PNG scanline unfilter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

   localparam int LINE_BYTES  = 8192;
   localparam int COL_W       = $clog2(LINE_BYTES);
   localparam int LEN_W       = 14;
   localparam int PIXEL_BYTES = 8;
   localparam int HIST_W      = $clog2(PIXEL_BYTES);
   localparam int PIX_W       = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 14;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_BYTES  = 1'b0,
      CSR_PIXEL_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             first_row;
      filter_type       filter;
      logic [7:0]       data;
      logic             last;
   } item_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [7:0]       data;
   } mem_wr_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_adv;
   } recon_stat_type;

endpackage

`default_nettype wire

/* hdl/psu_line_store.sv */
// Line store holding the previous rebuilt scanline, one byte per column.
// Depends on psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_line_store
   import psu_pkg::*;
(
   input  wire logic       clock,
   input  wire mem_rd_type rd,
   input  wire mem_wr_type wr,
   output logic [7:0]      rd_data
);

   logic [7:0] mem [LINE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // pass the byte being written straight to a read of the same column
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && (wr.addr == rd.addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/psu_front.sv */
// Front stage: filter code capture, column tracking and line store read issue.
// Depends on psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_front
   import psu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire logic [7:0]       req_raw_byte,
   input  wire logic             req_image_start,
   input  wire logic [LEN_W-1:0] line_len,
   output logic                  issue,
   output item_type              item,
   output mem_rd_type            rd
);

   logic [COL_W-1:0] column_ff, column_in;
   logic             awaiting_ff, awaiting_in;
   logic             first_row_ff, first_row_in;
   filter_type       filter_ff, filter_in;
   logic             accept, awaiting, first_row;
   logic [LEN_W-1:0] col_next;

   assign accept    = req_valid && req_ready;
   assign awaiting  = req_image_start || awaiting_ff;
   assign first_row = req_image_start || first_row_ff;
   assign col_next  = LEN_W'(column_ff) + LEN_W'(1);

   always_comb begin
      item.col       = column_ff;
      item.first_row = first_row;
      item.filter    = filter_ff;
      item.data      = req_raw_byte;
      item.last      = (col_next >= line_len);
      issue          = accept && !awaiting;
      rd.en          = issue;
      rd.addr        = column_ff;

      column_in    = column_ff;
      awaiting_in  = awaiting_ff;
      first_row_in = first_row_ff;
      filter_in    = filter_ff;
      if (accept) begin
         first_row_in = first_row;
         if (awaiting) begin
            filter_in   = (req_raw_byte <= 8'(FILT_PAETH)) ?
                          filter_type'(req_raw_byte[2:0]) : FILT_NONE;
            awaiting_in = 1'b0;
            column_in   = '0;
         end else if (item.last) begin
            awaiting_in  = 1'b1;
            column_in    = '0;
            first_row_in = 1'b0;
         end else begin
            column_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         awaiting_ff  <= 1'b1;
         first_row_ff <= 1'b1;
         filter_ff    <= FILT_NONE;
      end else begin
         column_ff    <= column_in;
         awaiting_ff  <= awaiting_in;
         first_row_ff <= first_row_in;
         filter_ff    <= filter_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/psu_recon.sv */
// Reconstruction stage: predictor, neighbour history, write-back and output word.
// Depends on psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_recon
   import psu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             issue,
   input  wire item_type         item,
   input  wire logic [7:0]       above_raw,
   input  wire logic [PIX_W-1:0] pixel_bytes,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_pixel_byte,
   output logic                  rsp_row_end,
   output mem_wr_type            wr,
   output recon_stat_type        stat
);

   function automatic logic [10:0] abs11(input logic signed [10:0] v);
      return (v < 0) ? 11'(-v) : 11'(v);
   endfunction

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [10:0] p;
      logic [10:0]        pa, pb, pc;
      p  = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({3'b0, c});
      pa = abs11(p - $signed({3'b0, a}));
      pb = abs11(p - $signed({3'b0, b}));
      pc = abs11(p - $signed({3'b0, c}));
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   logic             s1_valid_ff, s1_valid_in;
   item_type         s1_ff;
   logic [7:0]       left_ff [PIXEL_BYTES];
   logic [7:0]       upleft_ff [PIXEL_BYTES];
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       pixel_ff;
   logic             row_end_ff;
   logic             s1_adv, has_left;
   logic [HIST_W-1:0] pix_idx;
   logic [7:0]       left, above, upleft, pred, result;
   logic [8:0]       avg_sum;

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pix_idx  = HIST_W'(pixel_bytes - PIX_W'(1));
   assign has_left = (s1_ff.col >= COL_W'(pixel_bytes));
   assign left     = has_left ? left_ff[pix_idx] : 8'd0;
   assign upleft   = has_left ? upleft_ff[pix_idx] : 8'd0;
   assign above    = s1_ff.first_row ? 8'd0 : above_raw;
   assign avg_sum  = {1'b0, left} + {1'b0, above};

   always_comb begin
      case (s1_ff.filter)
         FILT_SUB:   pred = left;
         FILT_UP:    pred = above;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth(left, above, upleft);
         default:    pred = 8'd0;
      endcase
      result = s1_ff.data + pred;

      wr.en   = s1_adv;
      wr.addr = s1_ff.col;
      wr.data = result;

      s1_valid_in = issue ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      stat.s1_valid = s1_valid_ff;
      stat.s1_adv   = s1_adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff <= item;
      end
      if (s1_adv) begin
         pixel_ff   <= result;
         row_end_ff <= s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIXEL_BYTES; k++) begin
            left_ff[k]   <= 8'd0;
            upleft_ff[k] <= 8'd0;
         end
      end else if (s1_adv) begin
         for (int k = PIXEL_BYTES - 1; k > 0; k--) begin
            left_ff[k]   <= left_ff[k-1];
            upleft_ff[k] <= upleft_ff[k-1];
         end
         left_ff[0]   <= result;
         upleft_ff[0] <= above;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = pixel_ff;
   assign rsp_row_end    = row_end_ff;

endmodule

`default_nettype wire

/* hdl/png_scanline_unfilter_top.sv */
// PNG scanline unfilter top level: configuration registers and stage wiring.
// Depends on psu_pkg, psu_front, psu_line_store and psu_recon.
//
//   channel  direction  word                          handshake
//   req      in         raw_byte, image_start         req_valid / req_ready
//   rsp      out        pixel_byte, row_end           rsp_valid / rsp_ready
//   csr      in         index, wdata                  csr_valid / csr_ready
//
// One byte per cycle sustained unless the output stalls; a data byte is registered
// with its line store read in the predictor stage, then in the output register.
// Filter code bytes are taken from the request channel and give no word.
// Left neighbours come from the result history written back in the same stage.
// Reset clears control state and history; the line store is not cleared.
// A stalled output holds one word plus one byte in the predictor stage.
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter_top
   import psu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_raw_byte,
   input  wire logic                   req_image_start,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_pixel_byte,
   output logic                        rsp_row_end,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [LEN_W-1:0] line_ff;
   logic [PIX_W-1:0] pixel_ff;
   logic [LEN_W-1:0] line_len;
   logic [PIX_W-1:0] pixel_bytes;
   logic             issue;
   item_type         item;
   mem_rd_type       rd;
   mem_wr_type       wr;
   logic [7:0]       above_raw;
   recon_stat_type   stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= LEN_W'(3);
         pixel_ff <= PIX_W'(3);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_BYTES:  line_ff  <= csr_wdata[LEN_W-1:0];
            CSR_PIXEL_BYTES: pixel_ff <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (line_ff == '0) begin
         line_len = LEN_W'(1);
      end else if (line_ff > LEN_W'(LINE_BYTES)) begin
         line_len = LEN_W'(LINE_BYTES);
      end else begin
         line_len = line_ff;
      end
      if (pixel_ff == '0) begin
         pixel_bytes = PIX_W'(1);
      end else if (pixel_ff > PIX_W'(PIXEL_BYTES)) begin
         pixel_bytes = PIX_W'(PIXEL_BYTES);
      end else begin
         pixel_bytes = pixel_ff;
      end
   end

   assign req_ready = !stat.s1_valid || stat.s1_adv;

   psu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_raw_byte    (req_raw_byte),
      .req_image_start (req_image_start),
      .line_len        (line_len),
      .issue           (issue),
      .item            (item),
      .rd              (rd)
   );

   psu_line_store u_line_store (
      .clock   (clock),
      .rd      (rd),
      .wr      (wr),
      .rd_data (above_raw)
   );

   psu_recon u_recon (
      .clock          (clock),
      .reset          (reset),
      .issue          (issue),
      .item           (item),
      .above_raw      (above_raw),
      .pixel_bytes    (pixel_bytes),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .wr             (wr),
      .stat           (stat)
   );

   a_word_held : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_pixel_byte) && $stable(rsp_row_end)))
      else $error("output word changed or dropped while stalled");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (stat.s1_valid && !stat.s1_adv) |=> stat.s1_valid)
      else $error("predictor stage lost a stalled byte");

   a_issue_only_free : assert property (@(posedge clock) disable iff (reset)
      issue |-> (!stat.s1_valid || stat.s1_adv))
      else $error("byte issued over an occupied predictor stage");

   a_word_from_stage : assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> $past(stat.s1_adv))
      else $error("output word appeared without a predictor advance");

endmodule

`default_nettype wire
